FILE: design/dcf_pkg.sv
// ============================================================================
// dcf_pkg: shared types and constants for the directed cycle finder
// Holds the sizes of the edge store and vertex tables.
// ============================================================================
package dcf_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 1024;
    localparam int VW          = $clog2(MaxVertices);     // 0-based vertex index
    localparam int EW          = $clog2(MaxEdges);        // edge address
    localparam int ECW         = EW + 1;                  // edge count
    localparam int DW          = VW + 1;                  // path depth
    localparam int FW          = 7;                       // vertex field width

    typedef logic [VW-1:0]  t_vidx;
    typedef logic [EW-1:0]  t_eaddr;
    typedef logic [ECW-1:0] t_ecnt;
    typedef logic [DW-1:0]  t_depth;

    typedef struct packed {
        logic          mode;
        logic [FW-1:0] from_vertex;
        logic [FW-1:0] to_vertex;
    } t_in_item;

    typedef struct packed {
        logic          found;
        logic [FW-1:0] vertex;
        logic          last;
        logic          overflow;
    } t_out_item;

    typedef logic [FW-1:0] t_cfg;

    localparam logic [1:0] ColWhite = 2'd0;
    localparam logic [1:0] ColGray  = 2'd1;
    localparam logic [1:0] ColBlack = 2'd2;
endpackage

FILE: design/dcf_if.sv
// ============================================================================
// dcf_if: valid/ready channel
// Stream channels, each carrying one payload of a fixed package type per transaction.
// ============================================================================
interface dcf_in_if;
    import dcf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dcf_out_if;
    import dcf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dcf_cfg_if;
    import dcf_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dcf_ram.sv
// ============================================================================
// dcf_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module dcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/directed_cycle_finder_core.sv
// ============================================================================
// directed_cycle_finder_core: three-color DFS cycle finder
// Loads directed edges into a RAM and on a run item walks the graph with an
// explicit path stack, emitting the first cycle found.
// ============================================================================
// channel | dir | transaction
// i_in    | in  | mode/from_vertex/to_vertex: add edge or run search
// o_out   | out | found/vertex/last/overflow: one cycle vertex or "none"
// i_cfg   | in  | node_count write, taken only while idle
//
// Edge adds are taken back to back. Run: each root tried steps S_ROOT, S_RCOL;
// each edge read S_RD (address), S_CHK (compare), plus S_WCOL for an edge that
// leaves the current vertex; each popped vertex S_RD, S_TOP, S_TOPV, S_TOPK.
// A found cycle steps S_FIND, S_FCMP per path entry searched, S_EMITW per vertex
// emitted, S_EMIT between; no cycle: S_NONE. An output stall holds the emit state.
// After reset and after every run a clearing pass whitens the color RAM;
// input and config are not ready during a run or that pass.
// The edge RAM needs no clearing: only entries below the count are read.
// ============================================================================
module directed_cycle_finder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcf_in_if.sink      i_in,
    dcf_cfg_if.sink     i_cfg,
    dcf_out_if.source   o_out
);
    import dcf_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_ROOT  = 15'h0002,
        S_RCOL  = 15'h0004,
        S_TOP   = 15'h0008,
        S_TOPV  = 15'h0010,
        S_TOPK  = 15'h0020,
        S_RD    = 15'h0040,
        S_CHK   = 15'h0080,
        S_WCOL  = 15'h0100,
        S_FIND  = 15'h0200,
        S_FCMP  = 15'h0400,
        S_EMIT  = 15'h0800,
        S_EMITW = 15'h1000,
        S_NONE  = 15'h2000,
        S_CLR   = 15'h4000
    } t_state;

    t_state r_state;

    // configuration
    t_cfg r_node_count;

    // edge bookkeeping
    t_ecnt  r_edge_total;
    logic   r_dropped;

    // search state; colors, scan positions and the path live in RAMs
    t_depth r_depth;
    t_depth r_root;       // root counter, may reach MaxVertices
    t_depth r_n;          // saturated node count
    t_vidx  r_v;          // vertex on top of the path
    t_vidx  r_w;          // successor under test
    t_vidx  r_gray;       // vertex closing the cycle
    t_vidx  r_clr;        // color clear pointer
    t_ecnt  r_k;          // scan pointer
    t_depth r_emit;       // path index for search and emission

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // RAM ports
    logic            edge_we;
    t_eaddr          edge_addr;
    logic [2*VW-1:0] edge_wdata, edge_rdata;
    logic            col_we;
    t_vidx           col_addr;
    logic [1:0]      col_wdata, col_rdata;
    logic            scan_we;
    t_vidx           scan_addr;
    t_ecnt           scan_wdata, scan_rdata;
    logic            path_we;
    t_vidx           path_addr;
    t_vidx           path_wdata, path_rdata;

    dcf_ram #(.WIDTH(2*VW), .DEPTH(MaxEdges)) u_edges (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_addr (edge_addr),
        .i_wdata(edge_wdata),
        .o_rdata(edge_rdata)
    );

    dcf_ram #(.WIDTH(2), .DEPTH(MaxVertices)) u_color (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_addr (col_addr),
        .i_wdata(col_wdata),
        .o_rdata(col_rdata)
    );

    dcf_ram #(.WIDTH(ECW), .DEPTH(MaxVertices)) u_scan (
        .i_clk  (i_clk),
        .i_we   (scan_we),
        .i_addr (scan_addr),
        .i_wdata(scan_wdata),
        .o_rdata(scan_rdata)
    );

    dcf_ram #(.WIDTH(VW), .DEPTH(MaxVertices)) u_path (
        .i_clk  (i_clk),
        .i_we   (path_we),
        .i_addr (path_addr),
        .i_wdata(path_wdata),
        .o_rdata(path_rdata)
    );

    logic  in_fire;
    logic  cfg_fire;
    logic  add_ok;
    logic  out_free;
    logic  edge_hit;
    logic  push_ok;
    logic  emit_last;
    t_vidx rd_from, rd_to;

    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign add_ok = (i_in.data.from_vertex != '0) && (i_in.data.to_vertex != '0)
        && ({1'b0, i_in.data.from_vertex} <= (FW+1)'(MaxVertices))
        && ({1'b0, i_in.data.to_vertex} <= (FW+1)'(MaxVertices));

    assign rd_from   = edge_rdata[2*VW-1:VW];
    assign rd_to     = edge_rdata[VW-1:0];
    // successor edge of the top vertex that lands inside the searched range
    assign edge_hit  = (rd_from == r_v) && ({1'b0, rd_to} < r_n);
    assign push_ok   = (col_rdata == ColWhite) && (r_depth < t_depth'(MaxVertices));
    assign emit_last = (r_emit + t_depth'(1) == r_depth);
    assign out_free  = !r_out_valid || o_out.ready;

    // edge RAM: written on an accepted add, read by the scan pointer
    always_comb begin
        edge_we    = 1'b0;
        edge_addr  = r_k[EW-1:0];
        edge_wdata = {VW'(i_in.data.from_vertex - 1'b1), VW'(i_in.data.to_vertex - 1'b1)};
        if (r_state == S_IDLE) begin
            edge_addr = r_edge_total[EW-1:0];
            edge_we   = in_fire && !i_in.data.mode && add_ok
                        && (r_edge_total < ECW'(MaxEdges));
        end
    end

    // color RAM
    always_comb begin
        col_we    = 1'b0;
        col_addr  = r_v;
        col_wdata = ColWhite;
        case (r_state)
            S_ROOT: begin
                col_addr = r_root[VW-1:0];
            end
            S_RCOL: begin
                col_addr  = r_root[VW-1:0];
                col_we    = (col_rdata == ColWhite);
                col_wdata = ColGray;
            end
            S_RD: begin
                col_we    = (r_k >= r_edge_total);
                col_wdata = ColBlack;
            end
            S_CHK: begin
                col_addr = rd_to;
            end
            S_WCOL: begin
                col_addr  = r_w;
                col_we    = push_ok;
                col_wdata = ColGray;
            end
            S_CLR: begin
                col_addr = r_clr;
                col_we   = 1'b1;
            end
            default: col_addr = r_v;
        endcase
    end

    // scan position RAM; zeroed whenever a vertex turns gray
    always_comb begin
        scan_we    = 1'b0;
        scan_addr  = r_v;
        scan_wdata = '0;
        case (r_state)
            S_RCOL: begin
                scan_addr = r_root[VW-1:0];
                scan_we   = (col_rdata == ColWhite);
            end
            S_TOPV: begin
                scan_addr = path_rdata;
            end
            S_CHK: begin
                scan_we    = edge_hit;
                scan_wdata = r_k + t_ecnt'(1);
            end
            S_WCOL: begin
                scan_addr = r_w;
                scan_we   = push_ok;
            end
            default: scan_addr = r_v;
        endcase
    end

    // path stack RAM
    always_comb begin
        path_we    = 1'b0;
        path_addr  = r_emit[VW-1:0];
        path_wdata = r_w;
        case (r_state)
            S_RCOL: begin
                path_addr  = '0;
                path_we    = (col_rdata == ColWhite);
                path_wdata = r_root[VW-1:0];
            end
            S_TOP: begin
                path_addr = VW'(r_depth - t_depth'(1));
            end
            S_WCOL: begin
                path_addr = r_depth[VW-1:0];
                path_we   = push_ok;
            end
            default: path_addr = r_emit[VW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_node_count <= FW'(MaxVertices);
            r_edge_total <= '0;
            r_dropped    <= 1'b0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
            r_root       <= '0;
            r_n          <= '0;
            r_v          <= '0;
            r_w          <= '0;
            r_gray       <= '0;
            r_k          <= '0;
            r_emit       <= '0;
        end else begin
            if (cfg_fire) begin
                r_node_count <= i_cfg.data;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (!i_in.data.mode) begin
                            if (add_ok) begin
                                if (r_edge_total < ECW'(MaxEdges)) begin
                                    r_edge_total <= r_edge_total + 1'b1;
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                        end else begin
                            r_root  <= '0;
                            r_n     <= (r_node_count > FW'(MaxVertices))
                                       ? t_depth'(MaxVertices) : t_depth'(r_node_count);
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    // color of the candidate root is read here
                    if (r_root >= r_n) begin
                        r_state <= S_NONE;
                    end else begin
                        r_state <= S_RCOL;
                    end
                end
                S_RCOL: begin
                    r_root <= r_root + t_depth'(1);
                    if (col_rdata == ColWhite) begin
                        // root becomes the whole path, scan from edge 0
                        r_depth <= t_depth'(1);
                        r_v     <= r_root[VW-1:0];
                        r_k     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_ROOT;
                    end
                end
                S_TOP: begin
                    if (r_depth == '0) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_TOPV;
                    end
                end
                S_TOPV: begin
                    r_v     <= path_rdata;
                    r_state <= S_TOPK;
                end
                S_TOPK: begin
                    r_k     <= scan_rdata;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // edge r_k addressed this cycle; out of edges pops the vertex
                    if (r_k >= r_edge_total) begin
                        r_depth <= r_depth - t_depth'(1);
                        r_state <= S_TOP;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (edge_hit) begin
                        r_w     <= rd_to;
                        r_state <= S_WCOL;
                    end else begin
                        r_k     <= r_k + t_ecnt'(1);
                        r_state <= S_RD;
                    end
                end
                S_WCOL: begin
                    if (col_rdata == ColGray) begin
                        r_gray  <= r_w;
                        r_emit  <= '0;
                        r_state <= S_FIND;
                    end else if (push_ok) begin
                        r_depth <= r_depth + t_depth'(1);
                        r_v     <= r_w;
                        r_k     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_k     <= r_k + t_ecnt'(1);
                        r_state <= S_RD;
                    end
                end
                S_FIND: begin
                    r_state <= S_FCMP;
                end
                S_FCMP: begin
                    // the gray vertex is on the path by construction
                    if (path_rdata == r_gray) begin
                        r_state <= S_EMITW;
                    end else begin
                        r_emit  <= r_emit + t_depth'(1);
                        r_state <= S_FIND;
                    end
                end
                S_EMIT: begin
                    r_state <= S_EMITW;
                end
                S_EMITW: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out.found    <= 1'b1;
                        r_out.vertex   <= {1'b0, path_rdata} + FW'(1);
                        r_out.last     <= emit_last;
                        r_out.overflow <= r_dropped;
                        r_emit         <= r_emit + t_depth'(1);
                        if (emit_last) begin
                            r_edge_total <= '0;
                            r_depth      <= '0;
                            r_dropped    <= 1'b0;
                            r_clr        <= '0;
                            r_state      <= S_CLR;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_NONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out.found    <= 1'b0;
                        r_out.vertex   <= '0;
                        r_out.last     <= 1'b1;
                        r_out.overflow <= r_dropped;
                        r_edge_total   <= '0;
                        r_depth        <= '0;
                        r_dropped      <= 1'b0;
                        r_clr          <= '0;
                        r_state        <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + t_vidx'(1);
                    if (r_clr == t_vidx'(MaxVertices - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= ECW'(MaxEdges))
        else $error("edge count past capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("ready while searching");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("output changed while stalled");
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for directed_cycle_finder_core
// Streams edge and run transactions through the input channel, predicts every
// cycle report with a local depth-first search and checks each output
// transaction in order, under random idling, a long output hold-off and
// several node_count settings.
// ============================================================================
module tb_top;
    import dcf_pkg::*;

    localparam int CycleLimit = 2000000;

    logic i_clk;
    logic i_rst_n;

    dcf_in_if  in_ch ();
    dcf_cfg_if cfg_ch ();
    dcf_out_if out_ch ();

    directed_cycle_finder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Model state: loaded edges (0-based ends), search state, register
    int          edge_src[$];
    int          edge_dst[$];
    int          color[MaxVertices];
    int          scan_at[MaxVertices];
    int          path[MaxVertices];
    int          path_len;
    bit          dropped;
    int          node_count;

    t_out_item   cycle_q[$];
    int          fail_count;
    int          cycle_count;
    int          items_sent;
    int          runs_sent;
    int          reports_seen;
    bit          no_idle;
    int          out_wait;
    int          hold_req;
    int          hold_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void clear_graph();
        for (int i = 0; i < MaxVertices; i++) begin
            color[i]   = 0;
            scan_at[i] = 0;
        end
        edge_src.delete();
        edge_dst.delete();
        path_len = 0;
        dropped  = 1'b0;
    endfunction

    // Returns the 1-based gray vertex that closes a cycle, 0 if acyclic.
    function automatic int find_gray_hit(int n);
        int v;
        int k;
        int w;
        for (int root = 0; root < n; root++) begin
            if (color[root] != 0) continue;
            color[root]   = 1;
            scan_at[root] = 0;
            path[0]       = root;
            path_len      = 1;
            while (path_len > 0) begin
                v = path[path_len-1];
                k = scan_at[v];
                while (k < edge_src.size() && (edge_src[k] != v || edge_dst[k] >= n))
                    k++;
                if (k >= edge_src.size()) begin
                    // finished vertex leaves the path
                    scan_at[v] = k;
                    color[v]   = 2;
                    path_len--;
                    continue;
                end
                scan_at[v] = k + 1;
                w = edge_dst[k];
                if (color[w] == 1) return w + 1;
                if (color[w] == 0 && path_len < MaxVertices) begin
                    color[w]       = 1;
                    scan_at[w]     = 0;
                    path[path_len] = w;
                    path_len++;
                end
            end
        end
        return 0;
    endfunction

    function automatic void predict_item(t_in_item it);
        int        f;
        int        t;
        int        n;
        int        hit;
        int        i;
        t_out_item r;
        if (it.mode == 1'b0) begin
            f = it.from_vertex;
            t = it.to_vertex;
            // out-of-range ends are ignored without a flag
            if (f == 0 || t == 0 || f > MaxVertices || t > MaxVertices) return;
            if (edge_src.size() >= MaxEdges) begin
                dropped = 1'b1;
                return;
            end
            edge_src = {edge_src, f - 1};
            edge_dst = {edge_dst, t - 1};
            return;
        end
        n   = (node_count > MaxVertices) ? MaxVertices : node_count;
        hit = find_gray_hit(n);
        r.overflow = dropped;
        if (hit == 0) begin
            r.found  = 1'b0;
            r.vertex = '0;
            r.last   = 1'b1;
            cycle_q  = {cycle_q, r};
        end else begin
            i = 0;
            while (i < path_len && path[i] + 1 != hit) i++;
            for (int j = i; j < path_len; j++) begin
                r.found  = 1'b1;
                r.vertex = FW'(path[j] + 1);
                r.last   = (j + 1 == path_len);
                cycle_q  = {cycle_q, r};
            end
        end
        clear_graph();
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random ready gaps, optional long hold-off, checking
    // ------------------------------------------------------------------------
    // A requested hold-off starts once a result is waiting, so it stalls the
    // block mid-run.
    always @(negedge i_clk) begin
        if (hold_req > 0 && out_ch.valid) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (out_wait > 0) begin
            out_ch.ready <= 1'b0;
            out_wait--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            reports_seen++;
            out_wait = no_idle ? 0 : $urandom_range(0, 4);
            if (cycle_q.size() == 0) begin
                $error("unexpected output transaction: vertex %0d", got.vertex);
                fail_count++;
            end else begin
                want = cycle_q.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.vertex !== want.vertex) begin
                    $error("vertex: expected %0d, actual %0d", want.vertex, got.vertex);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    fail_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, actual %0d", want.overflow,
                           got.overflow);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Called right after the previous transaction's edge; valid stays high
    // across back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(bit mode, int f, int t);
        int       gap;
        t_in_item it;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        it.mode        = mode;
        it.from_vertex = FW'(f);
        it.to_vertex   = FW'(t);
        @(negedge i_clk);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= t_in_item'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
        if (mode) runs_sent++;
    endtask

    task automatic add_edge(int f, int t);
        send_item(1'b0, f, t);
    endtask

    task automatic run_search();
        send_item(1'b1, $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // Drop valid, let every expected report arrive, then wait until the block
    // is idle again after its clearing pass.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cycle_q.size() != 0 || !in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_node_count(int value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t_cfg'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        node_count = value & 8'h7f;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        run_search();                       // empty graph
        add_edge(64, 64);                   // self loop on the top vertex
        run_search();
        add_edge(1, 2);
        add_edge(2, 3);
        add_edge(3, 1);
        run_search();                       // 1,2,3
        add_edge(1, 2);
        add_edge(2, 64);
        run_search();                       // acyclic
        add_edge(0, 5);                     // out-of-range ends: ignored
        add_edge(65, 1);
        add_edge(127, 127);
        add_edge(5, 0);
        add_edge(1, 1);
        run_search();
        drain();
        write_node_count(3);                // edges past node_count skipped
        add_edge(4, 4);
        add_edge(1, 2);
        run_search();
        drain();
        write_node_count(0);                // nothing searched
        add_edge(1, 1);
        run_search();
        drain();
        write_node_count(127);              // saturates to all vertices
        add_edge(64, 1);
        add_edge(1, 64);
        run_search();
        drain();
        write_node_count(1);
        add_edge(1, 1);
        run_search();
        drain();
    endtask

    // One random graph followed by a run. Half are chains, most closed by a back
    // edge, so long cycles show up; the rest are loose random edges.
    task automatic random_graph(int n);
        int len;
        int v[$];
        int pick;
        if ($urandom_range(0, 1)) begin
            len = $urandom_range(1, (n < 12) ? n : 12);
            for (int i = 0; i < len; i++) v = {v, int'($urandom_range(1, n))};
            for (int i = 0; i + 1 < len; i++) add_edge(v[i], v[i+1]);
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, len - 1);
                add_edge(v[len-1], v[pick]);
            end
        end else begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    add_edge($urandom_range(0, 127), $urandom_range(0, 127));
                else
                    add_edge($urandom_range(1, n), $urandom_range(1, n));
            end
        end
        run_search();
    endtask

    task automatic test_random();
        int settings[4];
        settings = '{64, 1, $urandom_range(2, 8), $urandom_range(9, 64)};
        for (int p = 0; p < 4; p++) begin
            write_node_count(settings[p]);
            no_idle = (p == 2);
            for (int g = 0; g < 10; g++) random_graph(settings[p]);
            drain();
        end
        no_idle = 1'b0;
    endtask

    // Hold the output off while the sender keeps going, so the block stalls
    // in the middle of emitting a long cycle.
    task automatic test_backpressure();
        write_node_count(32);
        @(posedge i_clk);
        hold_req = 400;
        for (int i = 1; i < 24; i++) add_edge(i, i + 1);
        add_edge(24, 1);
        run_search();
        for (int i = 0; i < 6; i++) add_edge($urandom_range(1, 32), $urandom_range(1, 32));
        run_search();
        add_edge(7, 7);
        run_search();
        drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        items_sent   = 0;
        runs_sent    = 0;
        reports_seen = 0;
        no_idle      = 1'b0;
        out_wait     = 0;
        hold_req     = 0;
        hold_left    = 0;
        node_count   = 64;
        clear_graph();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        write_node_count(64);
        drain();

        if (cycle_q.size() != 0) begin
            $error("%0d expected reports never arrived", cycle_q.size());
            fail_count++;
        end
        $display("covered %0d input transactions, %0d searches, %0d reports checked",
                 items_sent, runs_sent, reports_seen);
        $display("incl. self loops, ignored ends, long output stall, node_count 0/1/64/127");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
